// ----- sv/mal_pkg.sv -----
// Shared types, constants and hash helpers for the MAC learning table.
package mal_pkg;

	localparam int BUCKETS  = 128;
	localparam int WAYS     = 4;
	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MAC_W    = 48;
	localparam int PORT_W   = 8;
	localparam int TIME_W   = 32;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_LEARN  = 2'd1;
	localparam logic [1:0] CMD_TOUCH  = 2'd2;
	localparam logic [1:0] CMD_DELETE = 2'd3;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_PRESENT   = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] stamp;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	typedef struct packed {
		logic                re;
		logic [BUCKET_W-1:0] raddr;
		logic                we;
		logic [BUCKET_W-1:0] waddr;
	} tbl_req_t;

	// Remainder by eleven of a value below 66.
	function automatic logic [3:0] mod11_small(input logic [6:0] v);
		logic [6:0] r;
		if (v >= 7'd55)      r = v - 7'd55;
		else if (v >= 7'd44) r = v - 7'd44;
		else if (v >= 7'd33) r = v - 7'd33;
		else if (v >= 7'd22) r = v - 7'd22;
		else if (v >= 7'd11) r = v - 7'd11;
		else                 r = v;
		return r[3:0];
	endfunction

endpackage

// ----- sv/mal_hash.sv -----
// Bucket hash: little-endian word mod 11, xor bytes 4 and 5, mod bucket count.
module mal_hash (
	input  logic [mal_pkg::MAC_W-1:0]    mac,
	output logic [mal_pkg::BUCKET_W-1:0] bucket
);

	logic [31:0] w;
	logic [11:0] s;
	logic [10:0] x;
	logic [6:0]  v;
	logic [3:0]  r;
	logic [7:0]  h;

	assign w = {mac[23:16], mac[31:24], mac[39:32], mac[47:40]};

	// 2^10 is 1 mod 11: fold the word into ten-bit chunks
	assign s = {2'b00, w[9:0]} + {2'b00, w[19:10]} + {2'b00, w[29:20]} + {10'd0, w[31:30]};
	assign x = {1'b0, s[9:0]} + {9'd0, s[11:10]};
	// 32 is -1 mod 11; add 33 to stay positive
	assign v = {2'b00, x[4:0]} + 7'd33 - {1'b0, x[10:5]};
	assign r = mal_pkg::mod11_small(v);

	assign h = {4'd0, r} ^ mac[15:8] ^ mac[7:0];
	assign bucket = h[mal_pkg::BUCKET_W-1:0];

endmodule

// ----- sv/mal_table.sv -----
// Bucket row memory: one row holds all ways of a bucket.
module mal_table (
	input  logic              clk,
	input  mal_pkg::tbl_req_t req,
	input  mal_pkg::row_t     wdata,
	output mal_pkg::row_t     rdata
);

	mal_pkg::row_t mem_q [mal_pkg::BUCKETS];
	mal_pkg::row_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/mac_address_learning_table_core.sv -----
// Top level of the MAC learning table: sequencer, way compare unit and result register.
// Usage:
//   Present cmd, mac_addr, port_id and now_time with start high; the beat is taken
//   at the rising edge where start is high and busy is low. Lookup, learn, touch
//   and delete each give exactly one result beat.
//   The result (found, port_out, status) is valid for one cycle while done is high.
//   The receiver cannot stall; the result must be captured in that cycle.
// Sequence:
//   After the accepting edge the block passes through S_HASH (bucket register), S_READ
//   (row read), S_SCAN (the ways one after another in the shared compare unit) and
//   S_WRITE (write-back). done rises as the block returns to S_IDLE, and a new beat
//   can be taken in that same cycle; no new beat is taken while one is in flight.
//   The pace is set by the single row read per beat and the one-way-per-cycle compare.
// Reset:
//   arst_n clears the control state; the block then runs a clearing pass over all
//   BUCKETS (128) rows of the row memory, one bucket per cycle, with busy high.
module mac_address_learning_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [47:0] mac_addr,
	input  logic [7:0]  port_id,
	input  logic [31:0] now_time,
	output logic        done,
	output logic        found,
	output logic [7:0]  port_out,
	output logic [1:0]  status
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_WRITE = 3'd5;

	localparam logic [mal_pkg::BUCKET_W-1:0] LAST_BUCKET =
		mal_pkg::BUCKET_W'(mal_pkg::BUCKETS - 1);
	localparam logic [mal_pkg::WAY_W-1:0] LAST_WAY = mal_pkg::WAY_W'(mal_pkg::WAYS - 1);

	logic [2:0] state_q;
	logic [mal_pkg::BUCKET_W-1:0] clr_idx_q;
	logic [mal_pkg::WAY_W-1:0]    way_q;
	logic [mal_pkg::WAY_W-1:0]    hit_way_q;
	logic [mal_pkg::WAY_W-1:0]    free_way_q;
	logic hit_q;
	logic free_q;
	logic done_q;

	logic [1:0]                   cmd_q;
	logic [mal_pkg::MAC_W-1:0]    mac_q;
	logic [mal_pkg::PORT_W-1:0]   port_q;
	logic [mal_pkg::TIME_W-1:0]   time_q;
	logic [mal_pkg::BUCKET_W-1:0] bucket_q;
	logic                         found_q;
	logic [mal_pkg::PORT_W-1:0]   port_out_q;
	logic [1:0]                   status_q;

	logic [mal_pkg::BUCKET_W-1:0] bucket_d;
	mal_pkg::tbl_req_t req;
	mal_pkg::row_t     rdata;
	mal_pkg::row_t     wrow;
	mal_pkg::way_t     cur_way;
	logic              upd_we;
	logic [1:0]        res_status;

	mal_hash u_hash (
		.mac    (mac_q),
		.bucket (bucket_d)
	);

	mal_table u_table (
		.clk   (clk),
		.req   (req),
		.wdata (wrow),
		.rdata (rdata)
	);

	assign cur_way = rdata[way_q];

	// Result and row update for the write-back cycle; an all-zero row during the clearing pass
	always_comb begin
		wrow       = rdata;
		upd_we     = 1'b0;
		res_status = mal_pkg::ST_NOT_FOUND;
		unique case (cmd_q)
			mal_pkg::CMD_LOOKUP: begin
				res_status = hit_q ? mal_pkg::ST_DONE : mal_pkg::ST_NOT_FOUND;
			end
			mal_pkg::CMD_LEARN: begin
				if (hit_q) begin
					res_status = mal_pkg::ST_PRESENT;
				end else if (free_q) begin
					res_status              = mal_pkg::ST_DONE;
					upd_we                  = 1'b1;
					wrow[free_way_q].valid  = 1'b1;
					wrow[free_way_q].mac    = mac_q;
					wrow[free_way_q].port   = port_q;
					wrow[free_way_q].stamp  = '0;
				end else begin
					res_status = mal_pkg::ST_FULL;
				end
			end
			mal_pkg::CMD_TOUCH: begin
				if (hit_q) begin
					res_status            = mal_pkg::ST_DONE;
					upd_we                = 1'b1;
					wrow[hit_way_q].stamp = time_q;
				end
			end
			mal_pkg::CMD_DELETE: begin
				if (hit_q) begin
					res_status            = mal_pkg::ST_DONE;
					upd_we                = 1'b1;
					wrow[hit_way_q].valid = 1'b0;
				end
			end
			default: begin
				res_status = mal_pkg::ST_NOT_FOUND;
			end
		endcase
		if (state_q == S_CLEAR) begin
			wrow = '0;
		end
	end

	always_comb begin
		req.re    = (state_q == S_READ);
		req.raddr = bucket_q;
		req.we    = (state_q == S_CLEAR) || ((state_q == S_WRITE) && upd_we);
		req.waddr = (state_q == S_CLEAR) ? clr_idx_q : bucket_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_idx_q  <= '0;
			way_q      <= '0;
			hit_way_q  <= '0;
			free_way_q <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_BUCKET) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					state_q <= S_READ;
				end
				S_READ: begin
					way_q   <= '0;
					hit_q   <= 1'b0;
					free_q  <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// keep the first matching way and the lowest free way
					if (!hit_q && cur_way.valid && (cur_way.mac == mac_q)) begin
						hit_q     <= 1'b1;
						hit_way_q <= way_q;
					end
					if (!free_q && !cur_way.valid) begin
						free_q     <= 1'b1;
						free_way_q <= way_q;
					end
					if (way_q == LAST_WAY) begin
						state_q <= S_WRITE;
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				S_WRITE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Input beat capture, bucket register and result register
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			cmd_q  <= cmd;
			mac_q  <= mac_addr;
			port_q <= port_id;
			time_q <= now_time;
		end
		if (state_q == S_HASH) begin
			bucket_q <= bucket_d;
		end
		if (state_q == S_WRITE) begin
			found_q    <= hit_q;
			port_out_q <= hit_q ? rdata[hit_way_q].port : '0;
			status_q   <= res_status;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign found    = found_q;
	assign port_out = port_out_q;
	assign status   = status_q;

endmodule

// ----- tb/tb_mac_address_learning_table_core.sv -----
// Self-checking testbench for the MAC learning table core: directed table, then random traffic.
module tb_mac_address_learning_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mal_pkg::*;

	localparam int ENTRY_CNT   = BUCKETS * WAYS;
	localparam int DRAIN_WAIT  = 3 * (3 + WAYS + 1);
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 550;
	localparam int POOL_SIZE   = 64;
	localparam int HOT_BUCKETS = 4;

	typedef struct packed {
		logic              found;
		logic [PORT_W-1:0] port;
		logic [1:0]        status;
	} outcome_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] now;
		logic              known;
		outcome_t          res;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        cmd;
	logic [MAC_W-1:0]  mac_addr;
	logic [PORT_W-1:0] port_id;
	logic [TIME_W-1:0] now_time;
	logic              done;
	logic              found;
	logic [PORT_W-1:0] port_out;
	logic [1:0]        status;

	// Fixed expectation for the beat on the inputs; otherwise the shadow table decides.
	logic     fixed_valid;
	outcome_t fixed_res;

	// Shadow copy of the table.
	logic              shadow_valid [ENTRY_CNT];
	logic [MAC_W-1:0]  shadow_mac   [ENTRY_CNT];
	logic [PORT_W-1:0] shadow_port  [ENTRY_CNT];
	logic [TIME_W-1:0] shadow_seen  [ENTRY_CNT];

	outcome_t         pending_results [$];
	dir_row_t         dir_table [$];
	logic [MAC_W-1:0] mac_pool [POOL_SIZE];
	logic [6:0]       hot_bucket [HOT_BUCKETS];
	int               error_count = 0;
	int               stall_cycles = 0;

	mac_address_learning_table_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.mac_addr (mac_addr),
		.port_id  (port_id),
		.now_time (now_time),
		.done     (done),
		.found    (found),
		.port_out (port_out),
		.status   (status)
	);

	always #6 clk = ~clk;

	function automatic logic [6:0] hash_bucket(input logic [MAC_W-1:0] mac);
		logic [31:0] word;
		logic [31:0] rem;
		logic [7:0]  mix;
		// byte 0 of the address is the low byte of the word
		word = {mac[23:16], mac[31:24], mac[39:32], mac[47:40]};
		rem  = word % 32'd11;
		mix  = rem[7:0] ^ mac[15:8] ^ mac[7:0];
		return mix[6:0];
	endfunction

	function automatic outcome_t table_access(input logic [1:0] op, input logic [MAC_W-1:0] mac,
			input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] now);
		outcome_t res;
		int       base;
		int       hit;
		base = int'(hash_bucket(mac)) * WAYS;
		hit  = -1;
		for (int w = 0; w < WAYS; w++) begin
			if (hit < 0 && shadow_valid[base + w] && shadow_mac[base + w] == mac)
				hit = base + w;
		end
		res.found  = (hit >= 0);
		res.port   = (hit >= 0) ? shadow_port[hit] : '0;
		res.status = ST_NOT_FOUND;
		case (op)
			CMD_LOOKUP: begin
				if (hit >= 0)
					res.status = ST_DONE;
			end
			CMD_LEARN: begin
				if (hit >= 0) begin
					res.status = ST_PRESENT;
				end else begin
					res.status = ST_FULL;
					// take the lowest free way
					for (int w = 0; w < WAYS; w++) begin
						if (res.status == ST_FULL && !shadow_valid[base + w]) begin
							shadow_valid[base + w] = 1'b1;
							shadow_mac[base + w]   = mac;
							shadow_port[base + w]  = port;
							shadow_seen[base + w]  = '0;
							res.status = ST_DONE;
						end
					end
				end
			end
			CMD_TOUCH: begin
				if (hit >= 0) begin
					shadow_seen[hit] = now;
					res.status = ST_DONE;
				end
			end
			default: begin
				if (hit >= 0) begin
					shadow_valid[hit] = 1'b0;
					res.status = ST_DONE;
				end
			end
		endcase
		return res;
	endfunction

	// Build an address that lands in the given bucket by fixing up byte 5.
	function automatic logic [MAC_W-1:0] mac_in_bucket(input logic [6:0] bkt);
		logic [MAC_W-1:0] mac;
		logic [6:0]       cur;
		mac = MAC_W'({$urandom, $urandom});
		cur = hash_bucket(mac);
		mac[6:0] = mac[6:0] ^ cur ^ bkt;
		return mac;
	endfunction

	task automatic add_row(input logic [1:0] op, input logic [MAC_W-1:0] mac,
			input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] now, input logic known,
			input logic f, input logic [PORT_W-1:0] p, input logic [1:0] st);
		dir_row_t row;
		row.op = op;
		row.mac = mac;
		row.port = port;
		row.now = now;
		row.known = known;
		row.res = '{found: f, port: p, status: st};
		dir_table.push_back(row);
	endtask

	task automatic send_beat(input logic [1:0] op, input logic [MAC_W-1:0] mac,
			input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] now, input logic known,
			input outcome_t res, input int idle_pct);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		cmd         <= op;
		mac_addr    <= mac;
		port_id     <= port;
		now_time    <= now;
		fixed_valid <= known;
		fixed_res   <= res;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic send_random(input int idle_pct);
		int               pick;
		logic [1:0]       op;
		logic [MAC_W-1:0] mac;
		pick = $urandom_range(99);
		if (pick < 25)      op = CMD_LOOKUP;
		else if (pick < 60) op = CMD_LEARN;
		else if (pick < 75) op = CMD_TOUCH;
		else                op = CMD_DELETE;
		pick = $urandom_range(99);
		if (pick < 60)      mac = mac_pool[$urandom_range(POOL_SIZE - 1)];
		else if (pick < 75) mac = mac_in_bucket(hot_bucket[$urandom_range(HOT_BUCKETS - 1)]);
		else                mac = MAC_W'({$urandom, $urandom});
		send_beat(op, mac, 8'($urandom), $urandom, 1'b0, '0, idle_pct);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Predict on every accepted beat, check every result beat, watch for stalls.
	always @(posedge clk) begin
		outcome_t want;
		outcome_t pred;
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation pending");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					error_count++;
				end
				if (port_out !== want.port) begin
					$error("port_out: expected %0d, got %0d", want.port, port_out);
					error_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
			end
		end
		if (arst_n && start && busy === 1'b0) begin
			pred = table_access(cmd, mac_addr, port_id, now_time);
			pending_results.push_back(fixed_valid ? fixed_res : pred);
		end
		if ((arst_n && start && busy === 1'b0) || done === 1'b1)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		dir_row_t row;
		logic [MAC_W-1:0] ones;
		logic [MAC_W-1:0] far;
		ones = '1;
		far  = 48'h0B00_0000_0000;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = CMD_LOOKUP;
		mac_addr    = '0;
		port_id     = '0;
		now_time    = '0;
		fixed_valid = 1'b0;
		fixed_res   = '0;
		for (int i = 0; i < ENTRY_CNT; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_mac[i]   = '0;
			shadow_port[i]  = '0;
			shadow_seen[i]  = '0;
		end

		// Zero, 0x0101, 0x0202, 0x0303 and 0x0B00_0000_0000 all hash to bucket zero.
		add_row(CMD_LOOKUP, '0,      8'h00, 32'h0,      1'b1, 1'b0, 8'h00, ST_NOT_FOUND);
		add_row(CMD_TOUCH,  ones,    8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, ST_NOT_FOUND);
		add_row(CMD_DELETE, '0,      8'h00, 32'h0,      1'b1, 1'b0, 8'h00, ST_NOT_FOUND);
		add_row(CMD_LEARN,  '0,      8'hFF, 32'h0,      1'b1, 1'b0, 8'h00, ST_DONE);
		add_row(CMD_LEARN,  '0,      8'h00, 32'h0,      1'b1, 1'b1, 8'hFF, ST_PRESENT);
		add_row(CMD_LOOKUP, '0,      8'h00, 32'h0,      1'b1, 1'b1, 8'hFF, ST_DONE);
		add_row(CMD_TOUCH,  '0,      8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, ST_DONE);
		add_row(CMD_LEARN,  ones,    8'h00, 32'h0,      1'b1, 1'b0, 8'h00, ST_DONE);
		add_row(CMD_LOOKUP, ones,    8'hFF, 32'h0,      1'b1, 1'b1, 8'h00, ST_DONE);
		add_row(CMD_LEARN,  48'h0101, 8'h01, 32'h0,     1'b1, 1'b0, 8'h00, ST_DONE);
		add_row(CMD_LEARN,  48'h0202, 8'h02, 32'h0,     1'b1, 1'b0, 8'h00, ST_DONE);
		add_row(CMD_LEARN,  48'h0303, 8'h03, 32'h0,     1'b1, 1'b0, 8'h00, ST_DONE);
		add_row(CMD_LEARN,  far,     8'h04, 32'h0,      1'b1, 1'b0, 8'h00, ST_FULL);
		add_row(CMD_LOOKUP, far,     8'h00, 32'h0,      1'b1, 1'b0, 8'h00, ST_NOT_FOUND);
		add_row(CMD_DELETE, 48'h0202, 8'h00, 32'h0,     1'b1, 1'b1, 8'h02, ST_DONE);
		add_row(CMD_DELETE, 48'h0202, 8'h00, 32'h0,     1'b1, 1'b0, 8'h00, ST_NOT_FOUND);
		add_row(CMD_LEARN,  far,     8'hA5, 32'h0,      1'b1, 1'b0, 8'h00, ST_DONE);
		add_row(CMD_LOOKUP, far,     8'h00, 32'h0,      1'b1, 1'b1, 8'hA5, ST_DONE);
		add_row(CMD_LEARN,  48'h0303, 8'h09, 32'h0,     1'b1, 1'b1, 8'h03, ST_PRESENT);
		add_row(CMD_DELETE, '0,      8'h00, 32'h0,      1'b1, 1'b1, 8'hFF, ST_DONE);
		add_row(CMD_LOOKUP, 48'h0101, 8'h00, 32'h0,     1'b1, 1'b1, 8'h01, ST_DONE);
		add_row(CMD_TOUCH,  48'h0303, 8'hFF, 32'h0,     1'b1, 1'b1, 8'h03, ST_DONE);
		add_row(CMD_DELETE, ones,    8'h00, 32'h0,      1'b1, 1'b1, 8'h00, ST_DONE);
		add_row(CMD_LEARN,  48'hAAAA_5555_AAAA, 8'h5A, 32'h5555_AAAA,
			1'b0, 1'b0, 8'h00, ST_DONE);
		add_row(CMD_LOOKUP, 48'hAAAA_5555_AAAA, 8'hA5, 32'hAAAA_5555,
			1'b0, 1'b0, 8'h00, ST_DONE);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_table[i]) begin
			row = dir_table[i];
			send_beat(row.op, row.mac, row.port, row.now, row.known, row.res, 0);
		end

		// Half the pool crowds a few buckets so full buckets and way reuse get hit.
		for (int i = 0; i < HOT_BUCKETS; i++)
			hot_bucket[i] = 7'($urandom);
		for (int i = 0; i < POOL_SIZE; i++)
			mac_pool[i] = (i % 2 == 0) ? mac_in_bucket(hot_bucket[i % HOT_BUCKETS])
			                           : MAC_W'({$urandom, $urandom});

		// Hold off until the table has answered everything.
		@(negedge clk);
		start <= 1'b0;
		fixed_valid <= 1'b0;
		wait_drained();

		for (int i = 0; i < PHASE_ITEMS; i++)
			send_random(38);
		@(negedge clk);
		start <= 1'b0;
		wait_drained();
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_random(76);
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_random(0);

		@(negedge clk);
		start <= 1'b0;
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
